### hdl/cpjq_pkg.sv
// cpjq_pkg: shared types and constants for the cost priority job queue.
// Used by the channel interfaces, the queue cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package cpjq_pkg;

    localparam int unsigned DEPTH_DEFAULT = 64;
    localparam int unsigned ID_W          = 16;
    localparam int unsigned COST_W        = 32;
    localparam int unsigned OCC_W         = 7;

    // action codes on the job channel
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // one stored job
    typedef struct packed {
        logic              valid;
        logic [COST_W-1:0] cost;
        logic [ID_W-1:0]   id;
    } t_entry;

    // command broadcast to every cell
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [COST_W-1:0] cost;
        logic [ID_W-1:0]   id;
    } t_ctl;

endpackage

`default_nettype wire

### hdl/cpjq_if.sv
// cpjq_job_if / cpjq_res_if: valid/ready channels for job items and result items.
// Depends on cpjq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cpjq_job_if import cpjq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [ID_W-1:0]   job_id;
    logic [COST_W-1:0] job_cost;

    modport source (output valid, action, job_id, job_cost, input ready);
    modport sink   (input valid, action, job_id, job_cost, output ready);
endinterface

interface cpjq_res_if import cpjq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              got_job;
    logic [ID_W-1:0]   out_id;
    logic [COST_W-1:0] out_cost;
    logic [OCC_W-1:0]  occupancy;
    logic              rejected;

    modport source (output valid, got_job, out_id, out_cost, occupancy, rejected,
                    input ready);
    modport sink   (input valid, got_job, out_id, out_cost, occupancy, rejected,
                    output ready);
endinterface

`default_nettype wire

### hdl/cpjq_cell.sv
// cpjq_cell: one slot of the sorted job chain; compares the broadcast cost
// and shifts with its neighbors. Depends on cpjq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpjq_cell import cpjq_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_ctl   i_ctl,
    input  wire t_entry i_up,      // neighbor toward the head (higher cost)
    input  wire logic   i_up_lt,   // neighbor's compare flag (its o_lt)
    input  wire t_entry i_dn,      // neighbor toward the tail (lower cost)
    output      t_entry o_entry,
    output      logic   o_lt
);

    t_entry r_entry;
    t_entry n_entry;

    // new job lands below every held job of cost >= its own
    assign o_lt = !r_entry.valid || (r_entry.cost < i_ctl.cost);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && o_lt) begin
            if (i_up_lt) begin
                n_entry = i_up;
            end else begin
                n_entry.valid = 1'b1;
                n_entry.cost  = i_ctl.cost;
                n_entry.id    = i_ctl.id;
            end
        end else if (i_ctl.rem) begin
            n_entry = i_dn;
        end
    end

    // payload carries no reset; only the valid flag is cleared
    always_ff @(posedge i_clk) begin
        r_entry.cost <= n_entry.cost;
        r_entry.id   <= n_entry.id;
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

### hdl/cost_priority_job_queue.sv
// cost_priority_job_queue: priority queue of jobs as a chain of sorted cells,
// head cell holds the highest cost. Depends on cpjq_pkg, cpjq_if, cpjq_cell.
//
//   channel  | dir | handshake           | payload
//   ---------+-----+---------------------+--------------------------------------
//   i_job    | in  | valid/ready         | action, job_id, job_cost
//   o_res    | out | valid/ready         | got_job, out_id, out_cost,
//            |     |                     | occupancy, rejected
//
// One item per cycle unless o_res stalls; a result is valid in the next cycle.
// The rate rests on the compare-and-shift every cell does combinationally.
// Reset clears the cell valid flags and the count directly, no clearing pass.
// i_job.ready drops only while a result is held and o_res.ready is low.
`timescale 1ns / 1ps
`default_nettype none

module cost_priority_job_queue import cpjq_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cpjq_job_if.sink  i_job,
    cpjq_res_if.source o_res
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_entry           w_cell  [DEPTH];
    logic             w_lt    [DEPTH];
    t_entry           w_up    [DEPTH];
    logic             w_up_lt [DEPTH];
    t_entry           w_dn    [DEPTH];
    t_ctl             w_ctl;

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_valid;
    logic              r_got;
    logic [ID_W-1:0]   r_id;
    logic [COST_W-1:0] r_cost;
    logic [OCC_W-1:0]  r_occ;
    logic              r_rej;

    logic w_accept;
    logic w_full;
    logic w_empty;

    assign i_job.ready = !r_valid || o_res.ready;
    assign w_accept    = i_job.valid && i_job.ready;
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_empty     = (r_count == '0);

    assign w_ctl.ins  = w_accept && (i_job.action == ACT_INSERT) && !w_full;
    assign w_ctl.rem  = w_accept && (i_job.action == ACT_REMOVE) && !w_empty;
    assign w_ctl.cost = i_job.job_cost;
    assign w_ctl.id   = i_job.job_id;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_up[g]    = '0;
            assign w_up_lt[g] = 1'b0;
        end else begin : g_mid
            assign w_up[g]    = w_cell[g-1];
            assign w_up_lt[g] = w_lt[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_dn[g] = '0;
        end else begin : g_body
            assign w_dn[g] = w_cell[g+1];
        end

        cpjq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_up    (w_up[g]),
            .i_up_lt (w_up_lt[g]),
            .i_dn    (w_dn[g]),
            .o_entry (w_cell[g]),
            .o_lt    (w_lt[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + CW'(1);
        end else if (w_ctl.rem) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload: head cell is the highest-cost job
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_got  <= w_ctl.rem;
            r_id   <= w_ctl.rem ? w_cell[0].id : '0;
            r_cost <= w_ctl.rem ? w_cell[0].cost : '0;
            r_occ  <= OCC_W'(n_count);
            r_rej  <= (i_job.action == ACT_INSERT) && w_full;
        end
    end

    assign o_res.valid     = r_valid;
    assign o_res.got_job   = r_got;
    assign o_res.out_id    = r_id;
    assign o_res.out_cost  = r_cost;
    assign o_res.occupancy = r_occ;
    assign o_res.rejected  = r_rej;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("count above depth");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cell[0].valid == !w_empty)
        else $error("head cell valid disagrees with count");

    a_tail_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cell[DEPTH-1].valid == w_full)
        else $error("tail cell valid disagrees with count");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cell[1].valid |-> (w_cell[0].cost >= w_cell[1].cost))
        else $error("head cells out of cost order");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.rem |=> (r_count == $past(r_count) - CW'(1)))
        else $error("remove did not lower count");

endmodule

`default_nettype wire
